/* src/bcc_pkg.sv */
package bcc_pkg;

    // Decoy store geometry
    localparam int DECOY_DEPTH = 16;
    localparam int PTR_W       = $clog2(DECOY_DEPTH);
    localparam int LEN_W       = 5;
    localparam int NUM_SYMBOLS = 12;

    // Item commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN    = 2'd1;
    localparam logic [1:0] STAT_NO_LETTERS = 2'd2;
    localparam logic [1:0] STAT_BAD_PATTERN = 2'd3;

    // Symbol alphabet, index order
    localparam logic [7:0] SYMBOLS [NUM_SYMBOLS] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h2C
    };

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_in;
        logic [3:0] load_index;
        logic       message_start;
    } req_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] status;
        logic       last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_DEC
    } ctrl_state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ENC,
        EMIT_UNKNOWN,
        EMIT_NO_LETTERS,
        EMIT_DECODE
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        emit_sel_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic sym_bad;
        logic no_letters;
        logic cur_letter;
        logic last_bit;
        logic group_done;
    } dp_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    // Bit 4 set when the character is not in the alphabet
    function automatic logic [4:0] symbol_lookup(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b10000;
        for (int i = NUM_SYMBOLS - 1; i >= 0; i--)
        begin
            if (SYMBOLS[i] == c)
            begin
                res = {1'b0, 4'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] symbol_char(input logic [3:0] idx);
        logic [7:0] res;
        res = 8'h00;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (idx == 4'(i))
            begin
                res = SYMBOLS[i];
            end
        end
        return res;
    endfunction

endpackage

/* src/bcc_ctrl.sv */
module bcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_cmd,
    output logic              req_stall,
    input  bcc_pkg::dp_stat_t stat,
    output bcc_pkg::dp_cmd_t  dp_cmd
);
    import bcc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one item at a time
    always_comb
    begin
        state_next    = state_reg;
        req_stall     = 1'b1;
        dp_cmd.accept = 1'b0;
        dp_cmd.emit   = EMIT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall     = 1'b0;
                dp_cmd.accept = req_valid;
                if (req_valid)
                begin
                    if (req_cmd == CMD_ENCODE)
                    begin
                        state_next = ST_ENC;
                    end
                    else if ((req_cmd == CMD_DECODE) && stat.group_done)
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_ENC:
            begin
                if (stat.slot_free)
                begin
                    priority if (stat.sym_bad)
                    begin
                        dp_cmd.emit = EMIT_UNKNOWN;
                        state_next  = ST_IDLE;
                    end
                    else if (stat.no_letters)
                    begin
                        dp_cmd.emit = EMIT_NO_LETTERS;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        dp_cmd.emit = EMIT_ENC;
                        if (stat.cur_letter && stat.last_bit)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_DEC:
            begin
                if (stat.slot_free)
                begin
                    dp_cmd.emit = EMIT_DECODE;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/bcc_datapath.sv */
module bcc_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcc_pkg::req_item_t     req_item,
    input  logic                   cfg_we,
    input  logic [4:0]             cfg_data,
    input  bcc_pkg::dp_cmd_t       dp_cmd,
    output bcc_pkg::dp_stat_t      stat,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output bcc_pkg::rsp_item_t     rsp_item
);
    import bcc_pkg::*;

    logic [7:0]       store_reg [DECOY_DEPTH];
    logic [DECOY_DEPTH-1:0] letter_reg;
    logic [DECOY_DEPTH-1:0] letter_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [3:0]       pat_reg;
    logic [3:0]       pat_next;
    logic [1:0]       seen_reg;
    logic [1:0]       seen_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic [3:0]       sym_reg;
    logic [3:0]       sym_next;
    logic             sym_bad_reg;
    logic             sym_bad_next;
    logic [1:0]       bit_reg;
    logic [1:0]       bit_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_item_t        rsp_item_reg;
    rsp_item_t        rsp_item_next;

    logic [LEN_W-1:0] eff_len;
    logic [DECOY_DEPTH-1:0] len_mask;
    logic [PTR_W-1:0] ptr_eff;
    logic [PTR_W-1:0] ptr_adv;
    logic [7:0]       cur_char;
    logic             cur_letter;
    logic [PTR_W-1:0] base_ptr;
    logic [3:0]       base_pat;
    logic [1:0]       base_seen;
    logic [3:0]       pat_shift;
    logic [4:0]       lookup;
    logic             in_letter;
    logic             slot_free;

    // Clamp the configured length to 1..DECOY_DEPTH
    always_comb
    begin
        priority if (length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(DECOY_DEPTH))
        begin
            eff_len = LEN_W'(DECOY_DEPTH);
        end
        else
        begin
            eff_len = length_reg;
        end
    end

    // Mark the positions inside the decoy
    always_comb
    begin
        for (int i = 0; i < DECOY_DEPTH; i++)
        begin
            len_mask[i] = (LEN_W'(i) < eff_len);
        end
    end

    // Wrap a stale pointer and step it circularly
    assign ptr_eff    = ({1'b0, ptr_reg} >= eff_len) ? '0 : ptr_reg;
    assign ptr_adv    = (({1'b0, ptr_eff} + LEN_W'(1)) == eff_len) ? '0 : ptr_eff + PTR_W'(1);
    assign cur_char   = store_reg[ptr_eff];
    assign cur_letter = is_letter(cur_char);

    // Message start clears pointer and partial pattern first
    assign base_ptr  = req_item.message_start ? '0 : ptr_reg;
    assign base_pat  = req_item.message_start ? '0 : pat_reg;
    assign base_seen = req_item.message_start ? '0 : seen_reg;
    assign in_letter = is_letter(req_item.char_in);
    assign pat_shift = {base_pat[2:0], is_lower(req_item.char_in)};
    assign lookup    = symbol_lookup(req_item.char_in);

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // Report status to the controller
    assign stat.slot_free  = slot_free;
    assign stat.sym_bad    = sym_bad_reg;
    assign stat.no_letters = ~|(letter_reg & len_mask);
    assign stat.cur_letter = cur_letter;
    assign stat.last_bit   = (bit_reg == 2'd0);
    assign stat.group_done = in_letter && (base_seen == 2'd3);

    // Next state of the cipher registers
    always_comb
    begin
        letter_next  = letter_reg;
        ptr_next     = ptr_reg;
        pat_next     = pat_reg;
        seen_next    = seen_reg;
        sym_next     = sym_reg;
        sym_bad_next = sym_bad_reg;
        bit_next     = bit_reg;
        length_next  = cfg_we ? cfg_data : length_reg;

        if (dp_cmd.accept)
        begin
            ptr_next  = base_ptr;
            pat_next  = base_pat;
            seen_next = base_seen;
            unique case (req_item.cmd)
                CMD_LOAD:
                begin
                    letter_next[req_item.load_index] = in_letter;
                end
                CMD_ENCODE:
                begin
                    sym_next     = lookup[3:0];
                    sym_bad_next = lookup[4];
                    bit_next     = 2'd3;
                end
                CMD_DECODE:
                begin
                    if (in_letter)
                    begin
                        if (base_seen == 2'd3)
                        begin
                            sym_next  = pat_shift;
                            pat_next  = '0;
                            seen_next = '0;
                        end
                        else
                        begin
                            pat_next  = pat_shift;
                            seen_next = base_seen + 2'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Advance through the decoy on each encoded character
        if (dp_cmd.emit == EMIT_ENC)
        begin
            ptr_next = ptr_adv;
            if (cur_letter)
            begin
                bit_next = bit_reg - 2'd1;
            end
        end
    end

    // Build the outgoing item
    always_comb
    begin
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (dp_cmd.emit)
            EMIT_NONE:
            begin
            end
            EMIT_ENC:
            begin
                rsp_valid_next         = 1'b1;
                rsp_item_next.status   = STAT_OK;
                rsp_item_next.last     = cur_letter && (bit_reg == 2'd0);
                if (cur_letter)
                begin
                    rsp_item_next.char_out = {cur_char[7:6], sym_reg[bit_reg], cur_char[4:0]};
                end
                else
                begin
                    rsp_item_next.char_out = cur_char;
                end
            end
            EMIT_UNKNOWN:
            begin
                rsp_valid_next = 1'b1;
                rsp_item_next  = '{char_out: 8'h00, status: STAT_UNKNOWN, last: 1'b1};
            end
            EMIT_NO_LETTERS:
            begin
                rsp_valid_next = 1'b1;
                rsp_item_next  = '{char_out: 8'h00, status: STAT_NO_LETTERS, last: 1'b1};
            end
            EMIT_DECODE:
            begin
                rsp_valid_next = 1'b1;
                rsp_item_next.last = 1'b1;
                if (sym_reg < 4'(NUM_SYMBOLS))
                begin
                    rsp_item_next.char_out = symbol_char(sym_reg);
                    rsp_item_next.status   = STAT_OK;
                end
                else
                begin
                    rsp_item_next.char_out = 8'h00;
                    rsp_item_next.status   = STAT_BAD_PATTERN;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_reg    <= '0;
            ptr_reg       <= '0;
            pat_reg       <= '0;
            seen_reg      <= '0;
            length_reg    <= LEN_W'(1);
            sym_bad_reg   <= 1'b0;
            bit_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            letter_reg    <= letter_next;
            ptr_reg       <= ptr_next;
            pat_reg       <= pat_next;
            seen_reg      <= seen_next;
            length_reg    <= length_next;
            sym_bad_reg   <= sym_bad_next;
            bit_reg       <= bit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        rsp_item_reg <= rsp_item_next;
        if (dp_cmd.accept && (req_item.cmd == CMD_LOAD))
        begin
            store_reg[req_item.load_index] <= req_item.char_in;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

/* src/baconian_case_cipher.sv */
// Baconian case cipher: hides the symbols 0-9, '-' and ',' in the letter
// case of a stored decoy text of up to 16 characters.
// Request channel (req_valid / req_stall / req_item): one item carries a
// command (load decoy character, encode symbol, decode character), a byte,
// a load position and a message start mark that rewinds the decoy pointer
// and clears the partial decode pattern before the item is handled.
// Response channel (rsp_valid / rsp_stall / rsp_item): character, status and
// a last flag on the final result of each request item.
// cfg_we / cfg_data write the decoy length; the user must write it only
// while the block is idle; the block does not enforce it. One item is
// handled at a time. Loads, and decodes that do not finish a group, leave
// the block idle; a decode that ends a group goes to the decode state,
// which registers its result when the output is free. An encode item
// gives four letters plus each non-letter passed, or one error result, at
// one character per unstalled cycle, paced by the single store read port.
// Reset clears pointer, pattern, letter flags and the output valid bit and
// sets the length to one; the decoy text must be loaded again.
// While rsp_stall is high the result is held and the block waits; a new
// item is still taken when the block is idle, even with a result pending.
module baconian_case_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bcc_pkg::req_item_t  req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bcc_pkg::rsp_item_t  rsp_item,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data
);
    import bcc_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;

    bcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_item.cmd),
        .req_stall (req_stall),
        .stat      (stat),
        .dp_cmd    (dp_cmd)
    );

    bcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

`ifndef SYNTHESIS
    // Error results always close their request item
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.status != STAT_OK)) |-> rsp_item.last)
        else $error("error result without last flag");

    // A load item leaves the block ready for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_item.cmd == CMD_LOAD)) |=> !req_stall)
        else $error("load item did not return to idle");

    // An encode item always occupies the block afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_item.cmd == CMD_ENCODE)) |=> req_stall)
        else $error("encode item not taken up");

    // No new item is taken while a result is being produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.emit != EMIT_NONE) |-> req_stall)
        else $error("item accepted during result generation");
`endif

endmodule

/* tb/baconian_case_cipher_tb.sv */
module baconian_case_cipher_tb;
    import bcc_pkg::*;

    // Command code with no function in the block
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Decoy text for the directed part: letter and non-letter boundaries
    localparam logic [7:0] DECOY_TEXT [DECOY_DEPTH] = '{
        8'h41, 8'h00, 8'h7A, 8'h40, 8'h5A, 8'h5B, 8'h61, 8'h60,
        8'h7B, 8'hFF, 8'h6D, 8'h51, 8'h20, 8'h72, 8'h42, 8'h6B
    };

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_item_t  req_item;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp_item;
    logic       cfg_we;
    logic [4:0] cfg_data;

    // Predicted state of the cipher
    logic [7:0] decoy_mem [DECOY_DEPTH];
    logic [3:0] decoy_ptr;
    logic [3:0] case_bits;
    logic [1:0] group_count;
    logic [4:0] length_reg;

    rsp_item_t   cipher_out_q [$];
    int unsigned error_count;
    bit          quiet;

    baconian_case_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic bit lower_case(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic int alphabet_index(input logic [7:0] c);
        int found;
        found = -1;
        for (int i = NUM_SYMBOLS - 1; i >= 0; i--)
        begin
            if (SYMBOLS[i] == c)
                found = i;
        end
        return found;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_nonletter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (alpha(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] rand_symbol();
        return SYMBOLS[$urandom_range(0, NUM_SYMBOLS - 1)];
    endfunction

    task automatic push_result(input logic [7:0] c, input logic [1:0] st, input logic lst);
        rsp_item_t r;
        r.char_out = c;
        r.status   = st;
        r.last     = lst;
        cipher_out_q.push_back(r);
    endtask

    // Advance the predicted state by one accepted item and queue its results
    task automatic cipher_step(input req_item_t it);
        int         len;
        int         p;
        int         sym;
        bit         any_letter;
        logic [7:0] c;
        if (it.message_start)
        begin
            decoy_ptr   = '0;
            case_bits   = '0;
            group_count = '0;
        end
        case (it.cmd)
            CMD_LOAD:
            begin
                decoy_mem[it.load_index] = it.char_in;
            end
            CMD_ENCODE:
            begin
                len = (length_reg == 0) ? 1 : (length_reg > DECOY_DEPTH) ? DECOY_DEPTH
                                                                             : length_reg;
                sym = alphabet_index(it.char_in);
                any_letter = 1'b0;
                for (int i = 0; i < len; i++)
                begin
                    if (alpha(decoy_mem[i]))
                        any_letter = 1'b1;
                end
                if (sym < 0)
                    push_result(8'h00, STAT_UNKNOWN, 1'b1);
                else if (!any_letter)
                    push_result(8'h00, STAT_NO_LETTERS, 1'b1);
                else
                begin
                    p = (decoy_ptr >= len) ? 0 : decoy_ptr;
                    for (int b = 3; b >= 0; b--)
                    begin
                        c = decoy_mem[p];
                        // pass non-letters through on the way to the next letter
                        while (!alpha(c))
                        begin
                            push_result(c, STAT_OK, 1'b0);
                            p = (p + 1) % len;
                            c = decoy_mem[p];
                        end
                        if (sym[b])
                            c = lower_case(c) ? c : c + 8'd32;
                        else
                            c = lower_case(c) ? c - 8'd32 : c;
                        push_result(c, STAT_OK, b == 0);
                        p = (p + 1) % len;
                    end
                    decoy_ptr = 4'(p);
                end
            end
            CMD_DECODE:
            begin
                if (alpha(it.char_in))
                begin
                    case_bits = {case_bits[2:0], lower_case(it.char_in)};
                    if (group_count < 3)
                        group_count = group_count + 2'd1;
                    else
                    begin
                        if (case_bits < NUM_SYMBOLS)
                            push_result(SYMBOLS[case_bits], STAT_OK, 1'b1);
                        else
                            push_result(8'h00, STAT_BAD_PATTERN, 1'b1);
                        case_bits   = '0;
                        group_count = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (cipher_out_q.size() == 0)
                report_mismatch("result with none predicted", rsp_item.char_out, 8'h00);
            else
            begin
                want = cipher_out_q.pop_front();
                if (rsp_item.char_out !== want.char_out)
                    report_mismatch("char_out", rsp_item.char_out, want.char_out);
                if (rsp_item.status !== want.status)
                    report_mismatch("status", 8'(rsp_item.status), 8'(want.status));
                if (rsp_item.last !== want.last)
                    report_mismatch("last", 8'(rsp_item.last), 8'(want.last));
            end
        end
    end

    // Result sink: stall for a random number of cycles before each item
    initial
    begin : rsp_sink
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_valid);
            @(negedge clk);
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [3:0] idx, input logic ms);
        int        gap;
        req_item_t it;
        it.cmd           = cmd;
        it.char_in       = ch;
        it.load_index    = idx;
        it.message_start = ms;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        cipher_step(it);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic hold_off();
        req_valid <= 1'b0;
        @(negedge clk);
        wait (cipher_out_q.size() == 0);
        @(negedge clk);
    endtask

    // Write the decoy length once the block has gone idle
    task automatic set_length(input logic [4:0] value);
        hold_off();
        repeat (8) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        length_reg = value;
    endtask

    task automatic test_decoy_load();
        for (int i = 0; i < DECOY_DEPTH; i++)
            send_item(CMD_LOAD, DECOY_TEXT[i], 4'(i), 1'b0);
    endtask

    task automatic test_encode_symbols();
        set_length(5'd16);
        send_item(CMD_ENCODE, SYMBOLS[0], 4'd0, 1'b1);
        send_item(CMD_ENCODE, SYMBOLS[NUM_SYMBOLS - 1], 4'd0, 1'b0);
        send_item(CMD_ENCODE, SYMBOLS[9], 4'd0, 1'b0);
        send_item(CMD_ENCODE, SYMBOLS[10], 4'd0, 1'b0);
        // characters outside the alphabet, near it and at the byte extremes
        send_item(CMD_ENCODE, 8'hFF, 4'd0, 1'b0);
        send_item(CMD_ENCODE, 8'h2F, 4'd0, 1'b0);
        send_item(CMD_ENCODE, 8'h00, 4'd0, 1'b0);
    endtask

    task automatic test_length_extremes();
        set_length(5'd31);
        send_item(CMD_ENCODE, SYMBOLS[5], 4'd0, 1'b0);
        set_length(5'd0);
        send_item(CMD_ENCODE, SYMBOLS[6], 4'd0, 1'b1);
    endtask

    task automatic test_no_letters();
        send_item(CMD_LOAD, 8'h23, 4'd0, 1'b0);
        set_length(5'd2);
        send_item(CMD_ENCODE, SYMBOLS[3], 4'd0, 1'b1);
        send_item(CMD_LOAD, 8'h41, 4'd0, 1'b0);
    endtask

    task automatic test_pointer_shrink();
        set_length(5'd16);
        send_item(CMD_ENCODE, SYMBOLS[7], 4'd0, 1'b1);
        send_item(CMD_ENCODE, SYMBOLS[2], 4'd0, 1'b0);
        // pointer now sits beyond the shorter length
        set_length(5'd3);
        send_item(CMD_ENCODE, SYMBOLS[1], 4'd0, 1'b0);
    endtask

    task automatic test_decode_groups();
        logic [7:0] text [12];
        text = '{8'h41, 8'h5A, 8'h41, 8'h61,
                 8'h7A, 8'h41, 8'h7A, 8'h7A,
                 8'h61, 8'h7A, 8'h41, 8'h5A};
        for (int i = 0; i < 12; i++)
        begin
            send_item(CMD_DECODE, text[i], 4'd0, i == 0);
            // a non-letter inside a group is skipped
            if (i == 5)
                send_item(CMD_DECODE, 8'h35, 4'd0, 1'b0);
        end
        send_item(CMD_DECODE, 8'h7A, 4'd0, 1'b0);
        send_item(CMD_DECODE, 8'h7A, 4'd0, 1'b0);
        // restart mid-group, via the unused command
        send_item(CMD_NOP, 8'hA5, 4'hF, 1'b1);
        for (int i = 0; i < 4; i++)
            send_item(CMD_DECODE, 8'h7A, 4'd0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         kind;
        int         n;
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] len;
        sent = 0;
        while (sent < 220)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            kind  = $urandom_range(0, 11);
            if (kind == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       len = 5'd0;
                    1:       len = 5'd1;
                    2:       len = 5'd16;
                    3:       len = 5'($urandom_range(17, 31));
                    default: len = 5'($urandom_range(1, 16));
                endcase
                set_length(len);
            end
            else if (kind <= 2)
            begin
                // rewrite a few decoy characters, mostly letters
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    ch = ($urandom_range(0, 9) < 7) ? rand_letter() : rand_nonletter();
                    send_item(CMD_LOAD, ch, 4'($urandom_range(0, 15)), 1'b0);
                end
                sent += n;
            end
            else if (kind <= 6)
            begin
                // encoded message, occasionally with a stray character
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : rand_symbol();
                    send_item(CMD_ENCODE, ch, 4'($urandom_range(0, 15)),
                              (i == 0) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 15) == 0));
                end
                sent += n;
            end
            else if (kind <= 10)
            begin
                // decoded message: groups of four letters with some noise
                n = 4 * $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_item(CMD_DECODE, rand_nonletter(), 4'd0, 1'b0);
                        sent++;
                    end
                    send_item(CMD_DECODE, rand_letter(), 4'($urandom_range(0, 15)),
                              (i == 0) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 31) == 0));
                end
                sent += n;
            end
            else
            begin
                // unstructured items
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    cmd = 2'($urandom_range(0, 3));
                    send_item(cmd, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)));
                end
                sent += n;
            end
            if ($urandom_range(0, 7) == 0)
                hold_off();
        end
        quiet = 1'b0;
    endtask

    initial
    begin : run_tests
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_item    = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        quiet       = 1'b0;
        decoy_ptr   = '0;
        case_bits   = '0;
        group_count = '0;
        length_reg  = 5'd1;
        for (int i = 0; i < DECOY_DEPTH; i++)
            decoy_mem[i] = 8'h00;

        // hold reset, release clear of an edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_decoy_load();
        test_encode_symbols();
        test_length_extremes();
        test_no_letters();
        test_pointer_shrink();
        test_decode_groups();
        test_random_traffic();

        // drain and let the block settle
        hold_off();
        repeat (20) @(negedge clk);
        if (error_count == 0 && cipher_out_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
